// ===== rtl/ssds_pkg.sv =====
// Shared types for the sparse-set dense store: request and response beats,
// action and status codes, and the controller state encoding.
// No dependencies; every other file in rtl/ refers to this package.
package ssds_pkg;

	typedef enum logic [1:0] {
		ACT_REGISTER = 2'd0,
		ACT_DELETE   = 2'd1,
		ACT_READ     = 2'd2,
		ACT_WRITE    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_ABSENT  = 2'd2,
		STAT_PRESENT = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR  = 2'd0,
		S_IDLE   = 2'd1,
		S_UPDATE = 2'd2,
		S_RESULT = 2'd3
	} state_t;

	typedef struct packed {
		action_t     action;
		logic [7:0]  entity_id;
		logic [31:0] write_datum;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  dense_slot;
		logic [31:0] read_datum;
		logic [8:0]  entity_count;
	} rsp_t;

endpackage

// ===== rtl/sparse_set_dense_store.sv =====
// Sparse-set table with swap-remove, keeping entity data packed in a dense store.
// After reset the block runs a clearing pass over all MAX_ENTITIES entries of the presence
// memory and holds req_stall high until it finishes. For each request, the accept edge reads
// the id maps, the presence bit and the last slot, and the following edge writes the maps
// back (and reads the datum for a read request); no new request is accepted before the
// result state. The response beat is loaded into the output register from the result
// state, once that register is empty or its beat is taken at the same edge; the next
// request is accepted at that same edge. While a stalled beat holds the output register,
// both the new result and the input wait.
// Depends on ssds_pkg.
module sparse_set_dense_store #(
	parameter int MAX_ENTITIES = 256,
	parameter int DATUM_WIDTH  = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  ssds_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output ssds_pkg::rsp_t   rsp
);

	localparam int IDX_W = $clog2(MAX_ENTITIES);
	localparam int CNT_W = $clog2(MAX_ENTITIES + 1);

	ssds_pkg::state_t state_q, state_d;
	logic [IDX_W-1:0] clr_q;
	logic [CNT_W-1:0] count_q;
	logic             req_accept;
	logic             out_free;
	logic             rsp_load;
	logic             in_update;

	logic [IDX_W-1:0] req_idx;
	logic [IDX_W-1:0] last_idx;
	logic             req_in_range;

	// Request stage, captured at the accept edge together with the map reads.
	ssds_pkg::action_t act_s1;
	logic [IDX_W-1:0]       id_s1;
	logic                   in_range_s1;
	logic [DATUM_WIDTH-1:0] wdat_s1;
	logic                   present_s1;
	logic [IDX_W-1:0]       slot_s1;
	logic [IDX_W-1:0]       moved_s1;
	logic [IDX_W-1:0]       last_s1;
	logic [DATUM_WIDTH-1:0] dd_rd_q;

	// Result stage.
	ssds_pkg::status_t status_s2;
	logic [IDX_W-1:0]  slot_s2;
	logic              rd_ok_s2;

	ssds_pkg::status_t upd_status;
	logic [IDX_W-1:0]  upd_slot;
	logic              upd_read;
	logic              reg_ok;
	logic              del_ok;
	logic              wr_ok;
	logic              do_move;

	ssds_pkg::rsp_t rsp_q;
	logic           rsp_valid_q;

	logic                   present_mem [MAX_ENTITIES];
	logic [IDX_W-1:0]       slot_mem    [MAX_ENTITIES];
	logic [IDX_W-1:0]       eos_mem     [MAX_ENTITIES];
	logic [DATUM_WIDTH-1:0] dense_mem   [MAX_ENTITIES];

	assign req_idx      = IDX_W'(req.entity_id);
	assign req_in_range = 32'(req.entity_id) < 32'(MAX_ENTITIES);
	assign last_idx     = IDX_W'(count_q - CNT_W'(1));
	assign req_accept   = req_valid && !req_stall;
	assign out_free     = !rsp_valid_q || !rsp_stall;
	assign rsp_load     = (state_q == ssds_pkg::S_RESULT) && out_free;
	assign in_update    = (state_q == ssds_pkg::S_UPDATE);

	// Controller: next state and input stall.
	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		case (state_q)
			ssds_pkg::S_CLEAR: begin
				if (clr_q == IDX_W'(MAX_ENTITIES - 1))
					state_d = ssds_pkg::S_IDLE;
			end
			ssds_pkg::S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid)
					state_d = ssds_pkg::S_UPDATE;
			end
			ssds_pkg::S_UPDATE: begin
				state_d = ssds_pkg::S_RESULT;
			end
			ssds_pkg::S_RESULT: begin
				if (out_free) begin
					req_stall = 1'b0;
					state_d   = req_valid ? ssds_pkg::S_UPDATE : ssds_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ssds_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ssds_pkg::S_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ssds_pkg::S_CLEAR)
				clr_q <= clr_q + IDX_W'(1);
			if (in_update && reg_ok)
				count_q <= count_q + CNT_W'(1);
			else if (in_update && del_ok)
				count_q <= count_q - CNT_W'(1);
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	// Decode of the captured request against the map contents.
	always_comb begin
		upd_status = ssds_pkg::STAT_OK;
		upd_slot   = slot_s1;
		upd_read   = 1'b0;
		reg_ok     = 1'b0;
		del_ok     = 1'b0;
		wr_ok      = 1'b0;
		if (!in_range_s1) begin
			upd_status = ssds_pkg::STAT_ABSENT;
			upd_slot   = '0;
		end else if (act_s1 == ssds_pkg::ACT_REGISTER) begin
			if (present_s1) begin
				upd_status = ssds_pkg::STAT_PRESENT;
				upd_slot   = '0;
			end else if (count_q == CNT_W'(MAX_ENTITIES)) begin
				upd_status = ssds_pkg::STAT_FULL;
				upd_slot   = '0;
			end else begin
				reg_ok   = 1'b1;
				upd_slot = IDX_W'(count_q);
			end
		end else if (!present_s1) begin
			upd_status = ssds_pkg::STAT_ABSENT;
			upd_slot   = '0;
		end else begin
			case (act_s1)
				ssds_pkg::ACT_DELETE: del_ok   = 1'b1;
				ssds_pkg::ACT_READ:   upd_read = 1'b1;
				ssds_pkg::ACT_WRITE:  wr_ok    = 1'b1;
				default: ;
			endcase
		end
	end

	// Deleting the entity in the last slot moves nothing.
	assign do_move = del_ok && (slot_s1 != last_s1);

	always_ff @(posedge clk) begin
		if (req_accept) begin
			act_s1      <= req.action;
			id_s1       <= req_idx;
			in_range_s1 <= req_in_range;
			wdat_s1     <= DATUM_WIDTH'(req.write_datum);
			last_s1     <= last_idx;
		end
		if (in_update) begin
			status_s2 <= upd_status;
			slot_s2   <= upd_slot;
			rd_ok_s2  <= upd_read;
		end
		if (rsp_load) begin
			rsp_q.status       <= status_s2;
			rsp_q.dense_slot   <= 8'(slot_s2);
			rsp_q.read_datum   <= rd_ok_s2 ? 32'(dd_rd_q) : 32'd0;
			rsp_q.entity_count <= 9'(count_q);
		end
	end

	// Presence bits: cleared by the pass after reset, then set and cleared per entity.
	always_ff @(posedge clk) begin
		if (state_q == ssds_pkg::S_CLEAR)
			present_mem[clr_q] <= 1'b0;
		else if (in_update && reg_ok)
			present_mem[id_s1] <= 1'b1;
		else if (in_update && del_ok)
			present_mem[id_s1] <= 1'b0;
		if (req_accept)
			present_s1 <= present_mem[req_idx];
	end

	always_ff @(posedge clk) begin
		if (in_update && reg_ok)
			slot_mem[id_s1] <= IDX_W'(count_q);
		else if (in_update && do_move)
			slot_mem[moved_s1] <= slot_s1;
		if (req_accept)
			slot_s1 <= slot_mem[req_idx];
	end

	always_ff @(posedge clk) begin
		if (in_update && reg_ok)
			eos_mem[IDX_W'(count_q)] <= id_s1;
		else if (in_update && do_move)
			eos_mem[slot_s1] <= moved_s1;
		if (req_accept)
			moved_s1 <= eos_mem[last_idx];
	end

	// The datum port reads the last slot at accept and the entity's slot during update;
	// the move in update still sees the last slot's datum in dd_rd_q.
	always_ff @(posedge clk) begin
		if (in_update && do_move)
			dense_mem[slot_s1] <= dd_rd_q;
		else if (in_update && wr_ok)
			dense_mem[slot_s1] <= wdat_s1;
		if (req_accept)
			dd_rd_q <= dense_mem[last_idx];
		else if (in_update)
			dd_rd_q <= dense_mem[slot_s1];
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/ssds_checker.sv =====
// Port-level checks for the sparse-set dense store, bound to the top level.
// Depends on ssds_pkg and sparse_set_dense_store.
module ssds_checker #(
	parameter int MAX_ENTITIES = 256
) (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input ssds_pkg::rsp_t rsp
);

	// A waiting response beat holds until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	// Accepted requests are never back to back.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted in the cycle after another");

	// After the update and result states of an accepted request the output holds a beat,
	// either this request's result or an older one that is still stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |-> ##3 rsp_valid)
		else $error("no response after an accepted request");

	// Error responses carry no slot and no datum.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ssds_pkg::STAT_OK |->
			rsp.dense_slot == 8'd0 && rsp.read_datum == 32'd0)
		else $error("error response with nonzero slot or datum");

	// A full store reports exactly MAX_ENTITIES live entities.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ssds_pkg::STAT_FULL |->
			rsp.entity_count == 9'(MAX_ENTITIES))
		else $error("store full reported below capacity");

endmodule

bind sparse_set_dense_store ssds_checker #(.MAX_ENTITIES(MAX_ENTITIES)) u_ssds_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for sparse_set_dense_store: directed table, fill and drain
// of the dense store, then random requests with random gaps and stalls on both sides.
// Depends on ssds_pkg and the sparse_set_dense_store RTL.
`timescale 1ns / 100ps

module tb_top;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 730;

	typedef struct {
		ssds_pkg::action_t act;
		logic [7:0]        id;
		logic [31:0]       dat;
		bit                typed;
		ssds_pkg::status_t st;
		logic [7:0]        slot;
		logic [31:0]       rd;
		logic [8:0]        cnt;
	} row_t;

	// Rows with typed = 0 are checked against the table mirror only.
	row_t dir_rows [23] = '{
		'{ssds_pkg::ACT_READ, 8'h05, 32'h0, 1'b1, ssds_pkg::STAT_ABSENT, 8'd0, 32'h0, 9'd0},
		'{ssds_pkg::ACT_DELETE, 8'h00, 32'h0, 1'b1, ssds_pkg::STAT_ABSENT, 8'd0, 32'h0, 9'd0},
		'{ssds_pkg::ACT_WRITE, 8'hFF, 32'hFFFFFFFF, 1'b1, ssds_pkg::STAT_ABSENT,
			8'd0, 32'h0, 9'd0},
		'{ssds_pkg::ACT_REGISTER, 8'h00, 32'h0, 1'b1, ssds_pkg::STAT_OK, 8'd0, 32'h0, 9'd1},
		'{ssds_pkg::ACT_REGISTER, 8'hFF, 32'h0, 1'b1, ssds_pkg::STAT_OK, 8'd1, 32'h0, 9'd2},
		'{ssds_pkg::ACT_REGISTER, 8'h00, 32'h0, 1'b1, ssds_pkg::STAT_PRESENT,
			8'd0, 32'h0, 9'd2},
		'{ssds_pkg::ACT_WRITE, 8'h00, 32'hFFFFFFFF, 1'b1, ssds_pkg::STAT_OK,
			8'd0, 32'h0, 9'd2},
		'{ssds_pkg::ACT_WRITE, 8'hFF, 32'h00000000, 1'b1, ssds_pkg::STAT_OK,
			8'd1, 32'h0, 9'd2},
		'{ssds_pkg::ACT_READ, 8'h00, 32'h0, 1'b1, ssds_pkg::STAT_OK,
			8'd0, 32'hFFFFFFFF, 9'd2},
		'{ssds_pkg::ACT_READ, 8'hFF, 32'h0, 1'b1, ssds_pkg::STAT_OK, 8'd1, 32'h0, 9'd2},
		'{ssds_pkg::ACT_REGISTER, 8'h55, 32'h0, 1'b0, ssds_pkg::STAT_OK, 8'd0, 32'h0, 9'd0},
		'{ssds_pkg::ACT_WRITE, 8'h55, 32'hA5A5A5A5, 1'b0, ssds_pkg::STAT_OK,
			8'd0, 32'h0, 9'd0},
		'{ssds_pkg::ACT_REGISTER, 8'hAA, 32'h0, 1'b0, ssds_pkg::STAT_OK, 8'd0, 32'h0, 9'd0},
		'{ssds_pkg::ACT_WRITE, 8'hAA, 32'h5A5A5A5A, 1'b0, ssds_pkg::STAT_OK,
			8'd0, 32'h0, 9'd0},
		'{ssds_pkg::ACT_DELETE, 8'h00, 32'h0, 1'b0, ssds_pkg::STAT_OK, 8'd0, 32'h0, 9'd0},
		'{ssds_pkg::ACT_READ, 8'hAA, 32'h0, 1'b0, ssds_pkg::STAT_OK, 8'd0, 32'h0, 9'd0},
		'{ssds_pkg::ACT_DELETE, 8'h55, 32'h0, 1'b0, ssds_pkg::STAT_OK, 8'd0, 32'h0, 9'd0},
		'{ssds_pkg::ACT_READ, 8'h55, 32'h0, 1'b1, ssds_pkg::STAT_ABSENT, 8'd0, 32'h0, 9'd2},
		'{ssds_pkg::ACT_REGISTER, 8'h01, 32'h0, 1'b0, ssds_pkg::STAT_OK, 8'd0, 32'h0, 9'd0},
		'{ssds_pkg::ACT_READ, 8'h01, 32'h0, 1'b0, ssds_pkg::STAT_OK, 8'd0, 32'h0, 9'd0},
		'{ssds_pkg::ACT_DELETE, 8'hAA, 32'h0, 1'b0, ssds_pkg::STAT_OK, 8'd0, 32'h0, 9'd0},
		'{ssds_pkg::ACT_READ, 8'h01, 32'h0, 1'b0, ssds_pkg::STAT_OK, 8'd0, 32'h0, 9'd0},
		'{ssds_pkg::ACT_DELETE, 8'hFF, 32'h0, 1'b0, ssds_pkg::STAT_OK, 8'd0, 32'h0, 9'd0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	ssds_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b1;
	ssds_pkg::rsp_t rsp;

	// Mirror of the sparse set; datum_known tracks slots whose datum was ever written.
	logic [7:0]  slot_of [256];
	bit          present [256];
	logic [7:0]  id_at [256];
	logic [31:0] datum_at [256];
	bit          datum_known [256];
	logic [8:0]  live = '0;

	ssds_pkg::rsp_t answer_q [$];
	int mismatches = 0;
	int cycles = 0;
	bit req_calm = 1'b0;
	bit rsp_calm = 1'b0;

	sparse_set_dense_store u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL sparse_set_dense_store");
			$finish;
		end
	end

	function automatic ssds_pkg::rsp_t apply_to_table(ssds_pkg::req_t r);
		ssds_pkg::rsp_t a;
		logic [7:0] s;
		logic [7:0] last;
		logic [7:0] moved;
		a = '0;
		a.status = ssds_pkg::STAT_OK;
		if (r.action == ssds_pkg::ACT_REGISTER) begin
			if (present[r.entity_id]) begin
				a.status = ssds_pkg::STAT_PRESENT;
			end else if (live == 9'd256) begin
				a.status = ssds_pkg::STAT_FULL;
			end else begin
				s = live[7:0];
				slot_of[r.entity_id] = s;
				id_at[s] = r.entity_id;
				present[r.entity_id] = 1'b1;
				live = live + 9'd1;
				a.dense_slot = s;
			end
		end else if (!present[r.entity_id]) begin
			a.status = ssds_pkg::STAT_ABSENT;
		end else begin
			s = slot_of[r.entity_id];
			a.dense_slot = s;
			case (r.action)
				ssds_pkg::ACT_DELETE: begin
					last = 8'(live - 9'd1);
					present[r.entity_id] = 1'b0;
					// Swap-remove: the entity in the last slot fills the hole.
					if (s != last) begin
						moved = id_at[last];
						datum_at[s] = datum_at[last];
						datum_known[s] = datum_known[last];
						id_at[s] = moved;
						slot_of[moved] = s;
					end
					live = live - 9'd1;
				end
				ssds_pkg::ACT_READ: begin
					a.read_datum = datum_at[s];
				end
				default: begin
					datum_at[s] = r.write_datum;
					datum_known[s] = 1'b1;
				end
			endcase
		end
		a.entity_count = live;
		return a;
	endfunction

	// A hit picks a live entity; a read of a slot whose datum was never written
	// is turned into a write.
	function automatic ssds_pkg::req_t make_request(ssds_pkg::action_t act, bit hit);
		ssds_pkg::req_t r;
		logic [7:0] id;
		if (hit && live != 0)
			id = id_at[$urandom_range(0, live - 1)];
		else
			id = 8'($urandom_range(0, 255));
		if (act == ssds_pkg::ACT_READ && present[id] && !datum_known[slot_of[id]])
			act = ssds_pkg::ACT_WRITE;
		r.action = act;
		r.entity_id = id;
		r.write_datum = $urandom;
		return r;
	endfunction

	task automatic send(input ssds_pkg::req_t r, input bit typed,
		input ssds_pkg::rsp_t typed_ans);
		ssds_pkg::rsp_t predicted;
		int gap;
		predicted = apply_to_table(r);
		if ($urandom_range(0, 39) == 0)
			req_calm = !req_calm;
		gap = req_calm ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall !== 1'b0);
		answer_q.push_back(typed ? typed_ans : predicted);
	endtask

	initial begin : rsp_side
		int n;
		ssds_pkg::rsp_t want;
		forever begin
			if ($urandom_range(0, 39) == 0)
				rsp_calm = !rsp_calm;
			n = rsp_calm ? 0 : $urandom_range(0, 19);
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (rsp_valid !== 1'b1);
			if (answer_q.size() == 0) begin
				$display("%0t: response beat with none expected, actual %p", $time, rsp);
				mismatches++;
			end else begin
				want = answer_q.pop_front();
				if (rsp.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, rsp.status);
					mismatches++;
				end
				if (rsp.dense_slot !== want.dense_slot) begin
					$display("%0t: dense_slot expected %0d actual %0d",
						$time, want.dense_slot, rsp.dense_slot);
					mismatches++;
				end
				if (rsp.read_datum !== want.read_datum) begin
					$display("%0t: read_datum expected %h actual %h",
						$time, want.read_datum, rsp.read_datum);
					mismatches++;
				end
				if (rsp.entity_count !== want.entity_count) begin
					$display("%0t: entity_count expected %0d actual %0d",
						$time, want.entity_count, rsp.entity_count);
					mismatches++;
				end
			end
		end
	end

	initial begin : req_side
		ssds_pkg::req_t r;
		ssds_pkg::rsp_t typed_ans;
		ssds_pkg::action_t act;
		int pick;
		int reg_cut;
		int del_cut;
		int read_cut;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			r.action = dir_rows[i].act;
			r.entity_id = dir_rows[i].id;
			r.write_datum = dir_rows[i].dat;
			typed_ans.status = dir_rows[i].st;
			typed_ans.dense_slot = dir_rows[i].slot;
			typed_ans.read_datum = dir_rows[i].rd;
			typed_ans.entity_count = dir_rows[i].cnt;
			send(r, dir_rows[i].typed, typed_ans);
		end

		// Fill every dense slot, work on the full store, then drain it completely.
		while (live != 9'd256) begin
			r = make_request(ssds_pkg::ACT_REGISTER, 1'b0);
			if (!present[r.entity_id])
				send(r, 1'b0, '0);
		end
		send(make_request(ssds_pkg::ACT_REGISTER, 1'b0), 1'b0, '0);
		r = make_request(ssds_pkg::ACT_WRITE, 1'b1);
		r.entity_id = id_at[255];
		send(r, 1'b0, '0);
		r.action = ssds_pkg::ACT_READ;
		send(r, 1'b0, '0);
		repeat (20) begin
			act = ($urandom_range(0, 1) == 0) ? ssds_pkg::ACT_READ : ssds_pkg::ACT_WRITE;
			send(make_request(act, 1'b1), 1'b0, '0);
		end
		while (live != 0) begin
			send(make_request(ssds_pkg::ACT_DELETE, 1'b1), 1'b0, '0);
			if ($urandom_range(0, 3) == 0)
				send(make_request(ssds_pkg::ACT_READ, 1'b1), 1'b0, '0);
		end

		// Mostly requests on live entities; the count drifts but stays mid-range.
		repeat (RANDOM_ITEMS) begin
			reg_cut = (live < 32) ? 45 : ((live > 224) ? 10 : 25);
			del_cut = reg_cut + ((live > 224) ? 35 : 20);
			read_cut = del_cut + (100 - del_cut) / 2;
			pick = $urandom_range(0, 99);
			if (pick < reg_cut) begin
				send(make_request(ssds_pkg::ACT_REGISTER, $urandom_range(0, 9) == 0),
					1'b0, '0);
			end else begin
				if (pick < del_cut)
					act = ssds_pkg::ACT_DELETE;
				else if (pick < read_cut)
					act = ssds_pkg::ACT_READ;
				else
					act = ssds_pkg::ACT_WRITE;
				send(make_request(act, $urandom_range(0, 99) < 85), 1'b0, '0);
			end
		end
		req_valid <= 1'b0;

		while (answer_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("PASS sparse_set_dense_store");
		else
			$display("FAIL sparse_set_dense_store");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/ssds_pkg.sv
rtl/sparse_set_dense_store.sv
rtl/ssds_checker.sv
tb/tb_top.sv
